@@ hw/rtl/ltsb_pkg.sv @@
// Shared types and constants for the LRU texture slot binder.
`default_nettype none

package ltsb_pkg;

  localparam int TEX_ID_W = 8;
  localparam int SLOT_W = 4;
  localparam int LIMIT_W = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [3:0] {
    CLEAR  = 4'b0001,
    IDLE   = 4'b0010,
    CHECK  = 4'b0100,
    UPDATE = 4'b1000
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/lru_texture_slot_binder_unit.sv @@
// Top level of the LRU texture slot binder: lookup memories, recency order and control.
// Flow: an accepted request moves through CHECK and UPDATE, and its result is loaded into
//   the output register in UPDATE. A new request is taken only back in IDLE, after the
//   texture table read, the slot owner read and the update, which waits while a stalled
//   result holds the output register. Reset: synchronous; clears the slot count and control,
//   sets slot_limit to 16, then clears all 256 texture table entries with requests stalled.
`default_nettype none

module lru_texture_slot_binder_unit #(
  parameter int SLOT_COUNT = 16,
  parameter int TEXTURE_COUNT = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ltsb_pkg::TEX_ID_W-1:0]     texture_id,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [ltsb_pkg::SLOT_W-1:0]            bound_slot,
  output logic                                   was_hit,
  output logic                                   did_evict,
  output logic [ltsb_pkg::TEX_ID_W-1:0]          evicted_texture,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ltsb_pkg::LIMIT_W-1:0]      cfg_data
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int TW = (TEXTURE_COUNT > 1) ? $clog2(TEXTURE_COUNT) : 1;

  // wrap an 8-bit index into the texture range
  function automatic logic [TW-1:0] wrap_tex(input logic [ltsb_pkg::TEX_ID_W-1:0] v);
    logic [TW-1:0] w;
    w = '0;
    for (int k = 0; k < 256; k++) begin
      if (v == 8'(k)) begin
        w = TW'(k % TEXTURE_COUNT);
      end
    end
    return w;
  endfunction

  ltsb_pkg::state_t state;

  logic [ltsb_pkg::LIMIT_W-1:0] slot_limit;
  logic [CW-1:0]                used;
  logic [CW-1:0]                lim_eff;
  logic [TW-1:0]                clear_addr;

  logic [SW-1:0] tex_mem [TEXTURE_COUNT];
  logic [TW-1:0] owner_mem [SLOT_COUNT];
  logic [SW-1:0] order [SLOT_COUNT];
  logic [SW-1:0] rank [SLOT_COUNT];

  logic [TW-1:0] tex;
  logic [SW-1:0] tslot;
  logic [TW-1:0] owner_rd_a;
  logic [TW-1:0] owner_rd_b;

  logic          accept;
  logic          out_free;
  logic          out_load;
  logic [SW-1:0] lru_slot;
  logic          hit;
  logic          full;
  logic [SW-1:0] sel_slot;
  logic [SW-1:0] sel_rank;
  logic          evict;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ltsb_pkg::IDLE);
  assign accept    = in_valid && (state == ltsb_pkg::IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == ltsb_pkg::UPDATE) && out_free;
  assign lru_slot  = order[SW'(used - CW'(1))];

  always_comb begin
    if (slot_limit == '0) begin
      lim_eff = CW'(1);
    end else if (32'(slot_limit) > 32'(SLOT_COUNT)) begin
      lim_eff = CW'(SLOT_COUNT);
    end else begin
      lim_eff = CW'(slot_limit);
    end
  end

  always_comb begin
    hit      = (CW'(tslot) < used) && (owner_rd_a == tex);
    full     = (used >= lim_eff);
    evict    = 1'b0;
    sel_slot = tslot;
    sel_rank = rank[tslot];
    if (!hit) begin
      if (!full) begin
        sel_slot = SW'(used);
        sel_rank = SW'(used);
      end else begin
        evict    = 1'b1;
        sel_slot = lru_slot;
        sel_rank = SW'(used - CW'(1));
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ltsb_pkg::CLEAR;
      clear_addr <= '0;
      used       <= '0;
      out_valid  <= 1'b0;
      slot_limit <= ltsb_pkg::LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        slot_limit <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ltsb_pkg::CLEAR: begin
          clear_addr <= clear_addr + TW'(1);
          if (clear_addr == TW'(TEXTURE_COUNT - 1)) begin
            state <= ltsb_pkg::IDLE;
          end
        end
        ltsb_pkg::IDLE: begin
          if (in_valid) begin
            state <= ltsb_pkg::CHECK;
          end
        end
        ltsb_pkg::CHECK: begin
          state <= ltsb_pkg::UPDATE;
        end
        ltsb_pkg::UPDATE: begin
          if (out_free) begin
            state <= ltsb_pkg::IDLE;
            if (!hit && !full) begin
              used <= used + CW'(1);
            end
          end
        end
        default: begin
          state <= ltsb_pkg::IDLE;
        end
      endcase
    end
  end

  // texture table
  always_ff @(posedge clk) begin
    if (accept) begin
      tslot <= tex_mem[wrap_tex(texture_id)];
    end
    if (state == ltsb_pkg::CLEAR) begin
      tex_mem[clear_addr] <= '0;
    end else if (out_load && !hit) begin
      tex_mem[tex] <= sel_slot;
    end
  end

  // slot owner table
  always_ff @(posedge clk) begin
    if (accept) begin
      owner_rd_b <= owner_mem[lru_slot];
    end
    if (state == ltsb_pkg::CHECK) begin
      owner_rd_a <= owner_mem[tslot];
    end
    if (out_load && !hit) begin
      owner_mem[sel_slot] <= tex;
    end
  end

  // request, recency order and result
  always_ff @(posedge clk) begin
    if (accept) begin
      tex <= wrap_tex(texture_id);
    end
    if (out_load) begin
      bound_slot      <= ltsb_pkg::SLOT_W'(sel_slot);
      was_hit         <= hit;
      did_evict       <= evict;
      evicted_texture <= evict ? ltsb_pkg::TEX_ID_W'(owner_rd_b) : '0;
      order[0]        <= sel_slot;
      for (int k = 1; k < SLOT_COUNT; k++) begin
        if (SW'(k) <= sel_rank) begin
          order[k] <= order[k-1];
        end
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (SW'(i) == sel_slot) begin
          rank[i] <= '0;
        end else if (rank[i] < sel_rank) begin
          rank[i] <= rank[i] + SW'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ test/lru_texture_slot_binder_checker.sv @@
`timescale 1ns / 100ps
// Checker for the LRU texture slot binder: predicts each slot binding and compares results.
module lru_texture_slot_binder_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [ltsb_pkg::TEX_ID_W-1:0] texture_id,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [ltsb_pkg::SLOT_W-1:0]   bound_slot,
  input  logic                          was_hit,
  input  logic                          did_evict,
  input  logic [ltsb_pkg::TEX_ID_W-1:0] evicted_texture,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ltsb_pkg::LIMIT_W-1:0]  cfg_data,
  output int                            failures,
  output int                            pending
);

  localparam int SLOTS = 16;
  localparam int TEXTURES = 256;

  typedef struct packed {
    logic [ltsb_pkg::SLOT_W-1:0]   slot;
    logic                          hit;
    logic                          evict;
    logic [ltsb_pkg::TEX_ID_W-1:0] victim;
  } binding_t;

  logic                          is_bound [TEXTURES];
  logic [ltsb_pkg::SLOT_W-1:0]   slot_of  [TEXTURES];
  logic [ltsb_pkg::TEX_ID_W-1:0] owner    [SLOTS];
  logic [ltsb_pkg::SLOT_W-1:0]   rank     [SLOTS];
  int                            used_slots;
  logic [ltsb_pkg::LIMIT_W-1:0]  limit;
  binding_t                      bindings_due [$];

  initial begin
    failures = 0;
    pending = 0;
  end

  // age every slot more recent than s, then make s most recent
  function automatic void make_most_recent(input int s);
    logic [ltsb_pkg::SLOT_W-1:0] r;
    r = rank[s];
    for (int i = 0; i < used_slots; i++) begin
      if (rank[i] < r) rank[i] = rank[i] + 1'b1;
    end
    rank[s] = '0;
  endfunction

  function automatic binding_t bind_texture(input logic [ltsb_pkg::TEX_ID_W-1:0] tex);
    binding_t b;
    int cap;
    int s;
    b = '0;
    cap = (limit == 0) ? 1 : ((limit > SLOTS) ? SLOTS : int'(limit));
    if (is_bound[tex]) begin
      b.hit = 1'b1;
      s = int'(slot_of[tex]);
      make_most_recent(s);
    end else begin
      if (used_slots < cap) begin
        s = used_slots;
        for (int i = 0; i < used_slots; i++) rank[i] = rank[i] + 1'b1;
        rank[s] = '0;
        used_slots++;
      end else begin
        s = 0;
        for (int i = 1; i < used_slots; i++) begin
          if (rank[i] > rank[s]) s = i;
        end
        b.evict = 1'b1;
        b.victim = owner[s];
        is_bound[owner[s]] = 1'b0;
        make_most_recent(s);
      end
      owner[s] = tex;
      slot_of[tex] = s[ltsb_pkg::SLOT_W-1:0];
      is_bound[tex] = 1'b1;
    end
    b.slot = s[ltsb_pkg::SLOT_W-1:0];
    return b;
  endfunction

  always @(posedge clk) begin
    binding_t want;
    if (rst) begin
      foreach (is_bound[t]) is_bound[t] = 1'b0;
      used_slots = 0;
      limit = ltsb_pkg::LIMIT_RESET;
      bindings_due.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) limit = cfg_data;
      if (out_valid && !out_stall) begin
        if (bindings_due.size() == 0) begin
          $error("result with no request waiting: bound_slot %0d", bound_slot);
          failures++;
        end else begin
          want = bindings_due.pop_front();
          if (bound_slot !== want.slot) begin
            $error("bound_slot: expected %0d, got %0d", want.slot, bound_slot);
            failures++;
          end
          if (was_hit !== want.hit) begin
            $error("was_hit: expected %0d, got %0d", want.hit, was_hit);
            failures++;
          end
          if (did_evict !== want.evict) begin
            $error("did_evict: expected %0d, got %0d", want.evict, did_evict);
            failures++;
          end
          if (evicted_texture !== want.victim) begin
            $error("evicted_texture: expected %0d, got %0d", want.victim, evicted_texture);
            failures++;
          end
        end
      end
      if (in_valid && !in_stall) bindings_due.push_back(bind_texture(texture_id));
      pending <= bindings_due.size();
    end
  end

endmodule

@@ test/lru_texture_slot_binder_unit_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the LRU texture slot binder: drives requests and limit writes.
module lru_texture_slot_binder_unit_test;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 55;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [ltsb_pkg::TEX_ID_W-1:0] texture_id = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [ltsb_pkg::SLOT_W-1:0]   bound_slot;
  logic                          was_hit;
  logic                          did_evict;
  logic [ltsb_pkg::TEX_ID_W-1:0] evicted_texture;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ltsb_pkg::LIMIT_W-1:0]  cfg_data = '0;
  int                            failures;
  int                            pending;
  int                            idle_pct = 9;
  int                            quiet_cycles = 0;

  always #6 clk = ~clk;

  lru_texture_slot_binder_unit i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .texture_id(texture_id),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .bound_slot(bound_slot),
    .was_hit(was_hit),
    .did_evict(did_evict),
    .evicted_texture(evicted_texture),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  lru_texture_slot_binder_checker i_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .texture_id(texture_id),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .bound_slot(bound_slot),
    .was_hit(was_hit),
    .did_evict(did_evict),
    .evicted_texture(evicted_texture),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .failures(failures),
    .pending(pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold the request until it is taken
  task automatic send_request(input logic [ltsb_pkg::TEX_ID_W-1:0] tex);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    texture_id <= tex;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drain all results before touching the limit
  task automatic write_limit(input logic [ltsb_pkg::LIMIT_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [ltsb_pkg::TEX_ID_W-1:0] opening [8];
    logic [ltsb_pkg::LIMIT_W-1:0]  limits [10];
    logic [ltsb_pkg::TEX_ID_W-1:0] base;
    logic [ltsb_pkg::TEX_ID_W-1:0] tex;
    int                            cap;
    int                            span;
    opening = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA};
    limits = '{5'd16, 5'd1, 5'd3, 5'd31, 5'd0, 5'd8, 5'd17, 5'd2, 5'd16, 5'd5};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[k]) send_request(opening[k]);
    // limit below the slots already in use
    write_limit(5'd2);
    send_request(8'h01);
    send_request(8'h00);
    send_request(8'h01);
    write_limit(5'd0);
    send_request(8'h02);
    send_request(8'h03);
    send_request(8'h03);
    // fill every slot, then evict
    write_limit(5'd31);
    for (int k = 0; k < 11; k++) send_request(8'h10 + k[7:0]);

    for (int p = 0; p < 10; p++) begin
      write_limit(limits[p]);
      idle_pct <= (p == 3) ? 0 : 9;
      cap = (limits[p] == 0) ? 1 : ((limits[p] > 16) ? 16 : int'(limits[p]));
      span = cap + $urandom_range(4);
      base = ltsb_pkg::TEX_ID_W'($urandom_range(255));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 80) begin
          tex = base + ltsb_pkg::TEX_ID_W'($urandom_range(span - 1));
        end else begin
          tex = ltsb_pkg::TEX_ID_W'($urandom_range(255));
        end
        send_request(tex);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
